FILE: sv/nab_pkg.sv
`default_nettype none
package nab_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 13;

   localparam int COLOR_W    = 8;
   localparam int PIX_W      = 3 * COLOR_W;
   localparam int TAPS       = 9;
   localparam int CENTER_TAP = 4;
   localparam int BLUR_SHIFT = $clog2(8);

   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 2);

   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);
   localparam logic [DIM_W-1:0] WIDTH_AT_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_AT_RESET = DIM_W'(480);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type pix;
      logic      frame_end;
   } result_type;

   typedef enum logic [2:0] {
      SEL_PASS,
      SEL_TAIL,
      SEL_CENTER,
      SEL_BLUR,
      SEL_MID
   } sel_type;

   typedef struct packed {
      logic    emit;
      logic    shift;
      logic    grab_tail;
      sel_type sel;
      logic    last;
   } stage_type;

endpackage
`default_nettype wire

FILE: sv/nab_req_if.sv
`default_nettype none
interface nab_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [nab_pkg::COLOR_W-1:0] in_red;
   logic [nab_pkg::COLOR_W-1:0] in_green;
   logic [nab_pkg::COLOR_W-1:0] in_blue;

   modport source (output valid, kind, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

FILE: sv/nab_rsp_if.sv
`default_nettype none
interface nab_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [nab_pkg::COLOR_W-1:0] out_red;
   logic [nab_pkg::COLOR_W-1:0] out_green;
   logic [nab_pkg::COLOR_W-1:0] out_blue;
   logic                        frame_end;

   modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

FILE: sv/nab_ram.sv
`default_nettype none
module nab_ram #(
   parameter int DEPTH  = 4096,
   parameter int DATA_W = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: sv/nab_out_fifo.sv
`default_nettype none
module nab_out_fifo (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire nab_pkg::result_type          push_data,
   output logic [nab_pkg::OUT_CNT_W-1:0]     count,
   nab_rsp_if.source                         rsp_chan
);

   nab_pkg::result_type                 slot_ff [nab_pkg::OUT_DEPTH];
   logic [nab_pkg::OUT_PTR_W-1:0]       wr_ptr_ff;
   logic [nab_pkg::OUT_PTR_W-1:0]       wr_ptr_in;
   logic [nab_pkg::OUT_PTR_W-1:0]       rd_ptr_ff;
   logic [nab_pkg::OUT_PTR_W-1:0]       rd_ptr_in;
   logic [nab_pkg::OUT_CNT_W-1:0]       count_ff;
   logic [nab_pkg::OUT_CNT_W-1:0]       count_in;
   logic                                pop;
   nab_pkg::result_type                 head;

   assign head               = slot_ff[rd_ptr_ff];
   assign rsp_chan.valid     = count_ff != '0;
   assign rsp_chan.out_red   = head.pix.red;
   assign rsp_chan.out_green = head.pix.green;
   assign rsp_chan.out_blue  = head.pix.blue;
   assign rsp_chan.frame_end = head.frame_end;
   assign pop                = rsp_chan.valid && rsp_chan.ready;
   assign count              = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == nab_pkg::OUT_PTR_W'(nab_pkg::OUT_DEPTH - 1)) ? '0
                     : wr_ptr_ff + nab_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == nab_pkg::OUT_PTR_W'(nab_pkg::OUT_DEPTH - 1)) ? '0
                     : rd_ptr_ff + nab_pkg::OUT_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + nab_pkg::OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - nab_pkg::OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/neighbor_average_blur_3x3_unit.sv
`default_nettype none
// channel   | direction | fields
// ----------+-----------+---------------------------------------------------
// req_chan  | in        | kind, in_red, in_green, in_blue (valid/ready)
// rsp_chan  | out       | out_red, out_green, out_blue, frame_end (valid/ready)
// csr_*     | in        | csr_write_en, csr_index, csr_write_data (write only)
//
// one item per clock while req_ready is high; a taken item passes the read stage register,
// where the row store rams are read, and then the output queue push before its result leaves.
// interior frames lag by width+1 items, which flush items drain after the last row.
// reset clears the position counters and sets 640x480; the row stores are not
// cleared, and entries never written are never routed to an output.
// req_ready falls when the 4-entry output queue plus the item in the read stage fill it.
module neighbor_average_blur_3x3_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [nab_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nab_pkg::DIM_W-1:0]     csr_write_data,
   nab_req_if.sink                            req_chan,
   nab_rsp_if.source                          rsp_chan
);

   logic [nab_pkg::DIM_W-1:0]     frame_width_ff;
   logic [nab_pkg::DIM_W-1:0]     frame_height_ff;
   logic [nab_pkg::COL_W-1:0]     w_last;
   logic [nab_pkg::ROW_W-1:0]     h_last;
   logic                          tiny_frame;

   logic [nab_pkg::COL_W-1:0]     in_column_ff;
   logic [nab_pkg::COL_W-1:0]     in_column_in;
   logic [nab_pkg::ROW_W-1:0]     in_row_ff;
   logic [nab_pkg::ROW_W-1:0]     in_row_in;
   logic                          input_done_ff;
   logic                          input_done_in;
   logic                          tail_done_ff;
   logic                          tail_done_in;

   logic                          req_fire;
   logic                          is_pixel;
   logic [nab_pkg::COL_W-1:0]     cur_col;
   logic [nab_pkg::ROW_W-1:0]     cur_row;
   logic                          row_end;

   nab_pkg::stage_type            s1_ctl_ff;
   nab_pkg::stage_type            s1_ctl_in;
   logic                          s1_valid_ff;
   logic [nab_pkg::COL_W-1:0]     s1_col_ff;
   nab_pkg::pixel_type            s1_pix_ff;
   logic                          s1_write;

   nab_pkg::pixel_type            up_rd;
   nab_pkg::pixel_type            mid_rd;
   nab_pkg::pixel_type            row_tail_ff;
   nab_pkg::pixel_type            win_ff [nab_pkg::TAPS];
   nab_pkg::pixel_type            win_in [nab_pkg::TAPS];
   nab_pkg::pixel_type            blur_pix;
   nab_pkg::pixel_type            res_pix;
   nab_pkg::result_type           push_data;
   logic                          push;
   logic [nab_pkg::OUT_CNT_W-1:0] out_count;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= nab_pkg::WIDTH_AT_RESET;
         frame_height_ff <= nab_pkg::HEIGHT_AT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            nab_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            nab_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // clamp the dimensions to [1, max] and keep them as last index
   always_comb begin
      if (frame_width_ff == '0) begin
         w_last = '0;
      end else if (32'(frame_width_ff) > nab_pkg::MAX_WIDTH) begin
         w_last = nab_pkg::COL_W'(nab_pkg::MAX_WIDTH - 1);
      end else begin
         w_last = nab_pkg::COL_W'(frame_width_ff - nab_pkg::DIM_W'(1));
      end
      if (frame_height_ff == '0) begin
         h_last = '0;
      end else if (32'(frame_height_ff) > nab_pkg::MAX_HEIGHT) begin
         h_last = nab_pkg::ROW_W'(nab_pkg::MAX_HEIGHT - 1);
      end else begin
         h_last = nab_pkg::ROW_W'(frame_height_ff - nab_pkg::DIM_W'(1));
      end
      tiny_frame = (w_last < nab_pkg::COL_W'(2)) || (h_last < nab_pkg::ROW_W'(2));
   end

   assign req_chan.ready = (out_count + nab_pkg::OUT_CNT_W'(s1_valid_ff))
                           < nab_pkg::OUT_CNT_W'(nab_pkg::OUT_DEPTH);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign is_pixel = req_chan.kind == nab_pkg::KIND_PIXEL;

   // a pixel after the input of a frame is complete starts a new frame
   assign cur_col = (is_pixel && input_done_ff) ? '0 : in_column_ff;
   assign cur_row = (is_pixel && input_done_ff) ? '0 : in_row_ff;
   assign row_end = cur_col == w_last;

   // position tracking and decode of what the item does in the ram stage
   always_comb begin
      in_column_in  = in_column_ff;
      in_row_in     = in_row_ff;
      input_done_in = input_done_ff;
      tail_done_in  = tail_done_ff;
      s1_ctl_in     = '0;
      if (csr_write_en) begin
         in_column_in  = '0;
         in_row_in     = '0;
         input_done_in = 1'b0;
         tail_done_in  = 1'b0;
      end else if (req_fire) begin
         if (is_pixel) begin
            input_done_in = 1'b0;
            tail_done_in  = 1'b0;
            in_row_in     = cur_row;
            if (row_end) begin
               in_column_in = '0;
               if (cur_row == h_last) begin
                  in_row_in     = '0;
                  input_done_in = !tiny_frame;
               end else begin
                  in_row_in = cur_row + nab_pkg::ROW_W'(1);
               end
            end else begin
               in_column_in = cur_col + nab_pkg::COL_W'(1);
            end
            if (tiny_frame) begin
               s1_ctl_in.emit = 1'b1;
               s1_ctl_in.sel  = nab_pkg::SEL_PASS;
               s1_ctl_in.last = row_end && (cur_row == h_last);
            end else begin
               s1_ctl_in.shift     = 1'b1;
               s1_ctl_in.grab_tail = row_end;
               s1_ctl_in.emit      = (cur_row >= nab_pkg::ROW_W'(2))
                                     || ((cur_row == nab_pkg::ROW_W'(1)) && (cur_col != '0));
               if (cur_col == '0) begin
                  s1_ctl_in.sel = nab_pkg::SEL_TAIL;
               end else if ((cur_row == nab_pkg::ROW_W'(1)) || (cur_col == nab_pkg::COL_W'(1)))
               begin
                  s1_ctl_in.sel = nab_pkg::SEL_CENTER;
               end else begin
                  s1_ctl_in.sel = nab_pkg::SEL_BLUR;
               end
            end
         end else if (input_done_ff && !tiny_frame) begin
            // drain: end of the next-to-last row, then the whole last row
            s1_ctl_in.emit = 1'b1;
            if (!tail_done_ff) begin
               s1_ctl_in.sel = nab_pkg::SEL_TAIL;
               tail_done_in  = 1'b1;
            end else begin
               s1_ctl_in.sel  = nab_pkg::SEL_MID;
               s1_ctl_in.last = row_end;
               if (row_end) begin
                  in_column_in  = '0;
                  in_row_in     = '0;
                  input_done_in = 1'b0;
                  tail_done_in  = 1'b0;
               end else begin
                  in_column_in = cur_col + nab_pkg::COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         input_done_ff <= 1'b0;
         tail_done_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         input_done_ff <= input_done_in;
         tail_done_ff  <= tail_done_in;
         s1_valid_ff   <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff <= s1_ctl_in;
      s1_col_ff <= cur_col;
      s1_pix_ff <= '{red: req_chan.in_red, green: req_chan.in_green, blue: req_chan.in_blue};
   end

   // consecutive items touch different columns, so a read never meets the
   // write of the item ahead of it at the same entry
   assign s1_write = s1_valid_ff && s1_ctl_ff.shift;

   nab_ram #(
      .DEPTH  (nab_pkg::MAX_WIDTH),
      .DATA_W (nab_pkg::PIX_W)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_addr (cur_col),
      .rd_data (up_rd)
   );

   nab_ram #(
      .DEPTH  (nab_pkg::MAX_WIDTH),
      .DATA_W (nab_pkg::PIX_W)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_addr (cur_col),
      .rd_data (mid_rd)
   );

   always_comb begin
      win_in = win_ff;
      if (s1_write) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = up_rd;
         win_in[3] = win_ff[4];
         win_in[4] = win_ff[5];
         win_in[5] = mid_rd;
         win_in[6] = win_ff[7];
         win_in[7] = win_ff[8];
         win_in[8] = s1_pix_ff;
      end
   end

   // eight neighbors, each pre-divided by 8, so the sum stays within 8 bits
   always_comb begin
      blur_pix = '0;
      for (int k = 0; k < nab_pkg::TAPS; k++) begin
         if (k != nab_pkg::CENTER_TAP) begin
            blur_pix.red   = blur_pix.red   + (win_in[k].red   >> nab_pkg::BLUR_SHIFT);
            blur_pix.green = blur_pix.green + (win_in[k].green >> nab_pkg::BLUR_SHIFT);
            blur_pix.blue  = blur_pix.blue  + (win_in[k].blue  >> nab_pkg::BLUR_SHIFT);
         end
      end
   end

   always_comb begin
      case (s1_ctl_ff.sel)
         nab_pkg::SEL_PASS:   res_pix = s1_pix_ff;
         nab_pkg::SEL_TAIL:   res_pix = row_tail_ff;
         nab_pkg::SEL_CENTER: res_pix = win_in[nab_pkg::CENTER_TAP];
         nab_pkg::SEL_BLUR:   res_pix = blur_pix;
         nab_pkg::SEL_MID:    res_pix = mid_rd;
         default:             res_pix = s1_pix_ff;
      endcase
   end

   // last column of a row moves from middle to upper store: keep it for the
   // edge copy owed when the next row starts
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (s1_valid_ff && s1_ctl_ff.grab_tail) begin
         row_tail_ff <= mid_rd;
      end
   end

   assign push      = s1_valid_ff && s1_ctl_ff.emit;
   assign push_data = '{pix: res_pix, frame_end: s1_ctl_ff.last};

   nab_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (out_count),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
